// ===== design/eod_pkg.sv =====
// ============================================================================
// eod_pkg: envelope onset detector package
// register indexes, reset values and field widths shared by the design
// ============================================================================
`default_nettype none

package eod_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 32;
    localparam int COEFF_W  = 16;
    localparam int ENV_W    = 24;
    localparam int SPACE_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t CFG_ATTACK_COEFF  = 3'd0;
    localparam cfg_idx_t CFG_RELEASE_COEFF = 3'd1;
    localparam cfg_idx_t CFG_RISE_RATIO    = 3'd2;
    localparam cfg_idx_t CFG_ONSET_FLOOR   = 3'd3;
    localparam cfg_idx_t CFG_MIN_SPACING   = 3'd4;

    // reset values
    localparam logic [COEFF_W-1:0] ATTACK_RST  = 16'd61964;
    localparam logic [COEFF_W-1:0] RELEASE_RST = 16'd65505;
    localparam logic [COEFF_W-1:0] RISE_RST    = 16'd1024;
    localparam logic [COEFF_W-1:0] FLOOR_RST   = 16'd1638;
    localparam logic [SPACE_W-1:0] SPACING_RST = 24'd4410;

    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

endpackage

`default_nettype wire

// ===== design/envelope_onset_detector.sv =====
// ============================================================================
// envelope_onset_detector: attack/release envelope onset detector
// flags samples whose magnitude jumps above a scaled envelope and a floor,
// spaced by a minimum sample distance, and reports each sample's index
// ============================================================================
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  s_      | in  | s_tvalid / s_tready | s_tdata = sample, s_tuser = block_start
//  m_      | out | m_tvalid / m_tready | m_tdata = onset_index, m_tuser = onset
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
//  one word per cycle sustained while the output is not stalled; a word
//  passes through the input register and then into the output register
//  the envelope loop sits between them: threshold and envelope update
//  (one 24x16 and one 17x26 multiply) complete in the cycle the word leaves
//  the input register
//  aresetn (synchronous, active low) restores register defaults and clears
//  envelope, index, onset history and both valid flags
//  a stalled output holds its word; the input register keeps taking words
//  as long as its contents can move into the output register
//
`default_nettype none

module envelope_onset_detector (
    input  wire         aclk,
    input  wire         aresetn,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,     // [15:0] sample (signed)
    input  wire  [0:0]  s_tuser,     // [0] block_start
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,     // [31:0] onset_index
    output logic [0:0]  m_tuser,     // [0] onset
    // configuration writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [23:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [eod_pkg::COEFF_W-1:0] attack_reg;
    logic [eod_pkg::COEFF_W-1:0] release_reg;
    logic [eod_pkg::COEFF_W-1:0] rise_reg;
    logic [eod_pkg::COEFF_W-1:0] floor_reg;
    logic [eod_pkg::SPACE_W-1:0] spacing_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= eod_pkg::ATTACK_RST;
            release_reg <= eod_pkg::RELEASE_RST;
            rise_reg    <= eod_pkg::RISE_RST;
            floor_reg   <= eod_pkg::FLOOR_RST;
            spacing_reg <= eod_pkg::SPACING_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                eod_pkg::CFG_ATTACK_COEFF:  attack_reg  <= cfg_data[15:0];
                eod_pkg::CFG_RELEASE_COEFF: release_reg <= cfg_data[15:0];
                eod_pkg::CFG_RISE_RATIO:    rise_reg    <= cfg_data[15:0];
                eod_pkg::CFG_ONSET_FLOOR:   floor_reg   <= cfg_data[15:0];
                eod_pkg::CFG_MIN_SPACING:   spacing_reg <= cfg_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                         in_valid_reg;
    logic [eod_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         start_reg;
    logic                         out_free;
    logic                         advance;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata;
            start_reg  <= s_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // detector state
    // ------------------------------------------------------------------
    logic [eod_pkg::ENV_W-1:0]   env_reg,   env_next;
    logic [eod_pkg::INDEX_W-1:0] count_reg, count_next;
    logic [eod_pkg::INDEX_W-1:0] last_reg,  last_next;
    logic                        seen_reg,  seen_next;

    // state as seen by this word: a block start wipes it first
    logic [eod_pkg::ENV_W-1:0]   env_cur;
    logic [eod_pkg::INDEX_W-1:0] count_cur;
    logic [eod_pkg::INDEX_W-1:0] last_cur;
    logic                        seen_cur;

    assign env_cur   = start_reg ? '0   : env_reg;
    assign count_cur = start_reg ? '0   : count_reg;
    assign last_cur  = start_reg ? '0   : last_reg;
    assign seen_cur  = start_reg ? 1'b0 : seen_reg;

    // magnitude, 0..32768
    logic [16:0] mag;
    assign mag = sample_reg[15] ? (17'd0 - {1'b1, sample_reg})
                                : {1'b0, sample_reg};

    // threshold: mag * 2^16 strictly above env * rise and floor * 2^16
    logic [39:0] env_thr;
    logic [39:0] mag_hi;
    logic        above_env;
    logic        above_floor;
    logic        spaced;
    logic        onset;
    logic [eod_pkg::INDEX_W-1:0] gap;

    assign env_thr     = {16'd0, env_cur} * {24'd0, rise_reg};
    assign mag_hi      = {7'd0, mag, 16'd0};
    assign above_env   = mag_hi > env_thr;
    assign above_floor = mag > {1'b0, floor_reg};
    assign gap         = count_cur - last_cur;
    assign spaced      = gap >= {8'd0, spacing_reg};
    assign onset       = above_env && above_floor && (!seen_cur || spaced);

    // envelope update: c*env + (1-c)*m8 = m8 + c*(env - m8), rounded half up
    logic [eod_pkg::ENV_W-1:0]   m8;
    logic [eod_pkg::COEFF_W-1:0] coeff;
    logic signed [25:0]          diff;
    logic signed [42:0]          prod;
    logic signed [43:0]          acc;

    assign m8    = {mag[15:0], 8'd0};
    assign coeff = (m8 > env_cur) ? attack_reg : release_reg;
    assign diff  = $signed({2'b00, env_cur}) - $signed({2'b00, m8});
    assign prod  = $signed({1'b0, coeff}) * diff;
    assign acc   = $signed({4'd0, m8, 16'd0}) + 44'(prod) + 44'sd32768;

    always_comb begin
        env_next   = acc[39:16];
        count_next = (count_cur == eod_pkg::INDEX_MAX) ? count_cur : count_cur + 32'd1;
        last_next  = onset ? count_cur : last_cur;
        seen_next  = seen_cur || onset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg   <= '0;
            count_reg <= '0;
            last_reg  <= '0;
            seen_reg  <= 1'b0;
        end else if (advance) begin
            env_reg   <= env_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            seen_reg  <= seen_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic                        out_valid_reg;
    logic [eod_pkg::INDEX_W-1:0] out_index_reg;
    logic                        out_onset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_index_reg <= count_cur;
            out_onset_reg <= onset;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_index_reg;
    assign m_tuser[0] = out_onset_reg;

endmodule

`default_nettype wire

// ===== design/eod_checker.sv =====
// ============================================================================
// eod_checker: port-level checks for the envelope onset detector
// watches reset, stall behavior and the progression of result indexes
// ============================================================================
`default_nettype none

module eod_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [15:0] s_tdata,
    input wire [0:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [0:0]  m_tuser
);

    // last delivered index, to check that indexes step by one, stick at max
    // or restart at zero
    logic [31:0] last_idx_reg;
    logic        have_idx_reg;
    logic        out_acc;

    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_idx_reg <= 1'b0;
        end else if (out_acc) begin
            have_idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_acc) begin
            last_idx_reg <= m_tdata;
        end
    end

    // nothing comes out right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // an input word waiting for ready holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("stalled input word changed");

    // with an empty output register the input side must take words
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // indexes advance by one, saturate, or restart on a new block
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && have_idx_reg |->
            (m_tdata == last_idx_reg + 32'd1) || (m_tdata == 32'd0) ||
            ((m_tdata == last_idx_reg) && (last_idx_reg == 32'hFFFF_FFFF)))
        else $error("result index out of sequence");

endmodule

bind envelope_onset_detector eod_checker u_eod_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/eod_check_pkg.sv =====
// ============================================================================
// eod_check_pkg: onset detector result checking
// predicts onset flag and sample index per input word and checks the
// result words against those predictions in order
// ============================================================================
`default_nettype none

package eod_check_pkg;

    import eod_pkg::*;

    typedef struct packed {
        logic               onset;
        logic [INDEX_W-1:0] index;
    } onset_result_t;

    typedef struct packed {
        logic [COEFF_W-1:0] attack;
        logic [COEFF_W-1:0] decay;
        logic [COEFF_W-1:0] rise;
        logic [COEFF_W-1:0] floor_lvl;
        logic [SPACE_W-1:0] spacing;
    } tuning_t;

    class onset_scoreboard;

        // register copy
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] decay_coeff;
        logic [COEFF_W-1:0] rise_ratio;
        logic [COEFF_W-1:0] floor_lvl;
        logic [SPACE_W-1:0] min_gap;

        // detector state
        logic [ENV_W-1:0]   envelope;
        logic [INDEX_W-1:0] next_index;
        logic [INDEX_W-1:0] last_onset;
        logic               onset_seen;

        onset_result_t      expected_q[$];
        int                 errors;
        int                 onsets;
        int                 quiet;

        function new();
            attack_coeff = ATTACK_RST;
            decay_coeff  = RELEASE_RST;
            rise_ratio   = RISE_RST;
            floor_lvl    = FLOOR_RST;
            min_gap      = SPACING_RST;
            errors       = 0;
            onsets       = 0;
            quiet        = 0;
            clear_block();
        endfunction

        function void clear_block();
            envelope   = '0;
            next_index = '0;
            last_onset = '0;
            onset_seen = 1'b0;
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction

        function void note_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ATTACK_COEFF:  attack_coeff = data[COEFF_W-1:0];
                CFG_RELEASE_COEFF: decay_coeff  = data[COEFF_W-1:0];
                CFG_RISE_RATIO:    rise_ratio   = data[COEFF_W-1:0];
                CFG_ONSET_FLOOR:   floor_lvl    = data[COEFF_W-1:0];
                CFG_MIN_SPACING:   min_gap      = data[SPACE_W-1:0];
                default: ;
            endcase
        endfunction

        // decision on the old envelope, then the attack/release update
        function void note_word(logic [SAMPLE_W-1:0] smp, logic blk);
            logic [16:0]   mag;
            logic [63:0]   mag_hi;
            logic [63:0]   level;
            logic [63:0]   floor_hi;
            logic [63:0]   env_w;
            logic [63:0]   mag8;
            logic [63:0]   coeff;
            logic [63:0]   acc;
            onset_result_t r;
            if (blk)
                clear_block();
            mag      = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
            mag_hi   = {47'b0, mag} << 16;
            env_w    = {40'b0, envelope};
            level    = env_w * {48'b0, rise_ratio};
            floor_hi = {48'b0, floor_lvl} << 16;
            if (floor_hi > level)
                level = floor_hi;
            r.onset = 1'b0;
            r.index = next_index;
            if ((mag_hi > level) &&
                (!onset_seen || ((next_index - last_onset) >= {8'b0, min_gap}))) begin
                r.onset    = 1'b1;
                onset_seen = 1'b1;
                last_onset = next_index;
            end
            mag8  = {47'b0, mag} << 8;
            coeff = (mag8 > env_w) ? {48'b0, attack_coeff} : {48'b0, decay_coeff};
            acc   = coeff * env_w + (64'd65536 - coeff) * mag8 + 64'd32768;
            envelope = acc[39:16];
            if (next_index != INDEX_MAX)
                next_index++;
            expected_q = {expected_q, r};
        endfunction

        function void check_word(logic [INDEX_W-1:0] tdata, logic tuser);
            onset_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: word with nothing expected, index %0d onset %0b",
                         $time, tdata, tuser);
                return;
            end
            want = expected_q.pop_front();
            if (tuser !== want.onset) begin
                errors++;
                $display("%0t: onset mismatch at index %0d, expected %0b actual %0b",
                         $time, want.index, want.onset, tuser);
            end
            if (tdata !== want.index) begin
                errors++;
                $display("%0t: index mismatch, expected %0d actual %0d",
                         $time, want.index, tdata);
            end
            if (want.onset)
                onsets++;
            else
                quiet++;
        endfunction

    endclass

endpackage

`default_nettype wire

// ===== tb/envelope_onset_detector_test.sv =====
// ============================================================================
// envelope_onset_detector_test: onset detector regression
// streams directed corner samples and randomized audio-like bursts through
// the detector under several register settings, with random gaps on both
// streams, and checks every result word against a cycle-free prediction
// ============================================================================
`default_nettype none

module envelope_onset_detector_test;

    import eod_pkg::*;
    import eod_check_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;      // margin past the input and output registers
    localparam int PHASE_WORDS  = 80;
    localparam int RAND_PHASES  = 5;
    localparam int STEADY_PHASE = 2;      // random phase run with no gaps

    // indexes past the register list, written to check they are ignored
    localparam cfg_idx_t CFG_SPARE_FIRST = 3'd5;
    localparam cfg_idx_t CFG_SPARE_LAST  = 3'd7;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;     // [15:0] sample (signed)
    logic [0:0]  s_tuser   = '0;     // [0] block_start
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // [31:0] onset_index
    logic [0:0]  m_tuser;            // [0] onset
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    onset_scoreboard sb;
    logic            steady   = 1'b0;   // suppresses gaps on both streams
    int              cycles   = 0;
    int              sent     = 0;
    int              settings = 0;

    envelope_onset_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake or lost word ends here
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, sb.waiting());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side backpressure, about 16 stall cycles in a hundred
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 16);
    end

    // result monitor, values seen here are the ones present at the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser[0]);
    end

    // one input word; valid stays up between back-to-back words
    task automatic send_word(input logic [15:0] smp, input logic blk);
        if (!steady) begin
            while ($urandom_range(99) < 16) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= smp;
        s_tuser[0] <= blk;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(smp, blk);
        sent++;
    endtask

    // stop the stream and let every outstanding result word come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(idx, data);
    endtask

    // all five registers plus one stray index; junk lands in the unused
    // upper bits of the 16-bit registers and must be dropped
    task automatic load_tuning(input tuning_t t, input logic [7:0] junk);
        wait_drained();
        write_reg(CFG_ATTACK_COEFF,  {junk, t.attack});
        write_reg(CFG_RELEASE_COEFF, {junk, t.decay});
        write_reg(CFG_RISE_RATIO,    {junk, t.rise});
        write_reg(CFG_ONSET_FLOOR,   {junk, t.floor_lvl});
        write_reg(CFG_MIN_SPACING,   t.spacing);
        write_reg($urandom_range(1) ? CFG_SPARE_FIRST : CFG_SPARE_LAST, {3{junk}});
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // value within range with the ends picked often
    function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return lo;
        if (roll < 24)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    // audio-like content: mostly low noise, loud hits, some full-scale edges
    function automatic logic [15:0] pick_sample();
        int          roll;
        int          v;
        logic [15:0] corners [6];
        corners = '{16'h8000, 16'h7FFF, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001};
        roll = $urandom_range(99);
        if (roll < 60) begin
            v = $urandom_range(600) - 300;
            return v[15:0];
        end
        if (roll < 85) begin
            v = $urandom_range(32767, 4000);
            if ($urandom_range(1))
                v = -v;
            return v[15:0];
        end
        if (roll < 92)
            return corners[$urandom_range(5)];
        return 16'($urandom);
    endfunction

    initial begin
        tuning_t t;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // default registers: first onset per block ignores spacing,
        // full-scale extremes on both signs, new block re-arms the onset
        send_word(16'h0000, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);
        send_word(16'd1000, 1'b0);

        // zero coefficients, ratio, floor and spacing: envelope follows the
        // magnitude at once and every sample that passes is an onset
        t = '{attack: '0, decay: '0, rise: '0, floor_lvl: '0, spacing: '0};
        load_tuning(t, 8'h00);
        send_word(16'h0000, 1'b1);
        send_word(16'h0005, 1'b0);
        send_word(16'hFFFB, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b0);

        // maxed registers: floor at full scale blocks every onset
        t = '{attack: '1, decay: '1, rise: '1, floor_lvl: 16'h8000, spacing: '1};
        load_tuning(t, 8'hFF);
        send_word(16'h8000, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h8001, 1'b0);

        // random settings, each phase opens a block then streams bursts
        for (int p = 0; p < RAND_PHASES; p++) begin
            t.attack    = 16'(pick_value(0, 65535));
            t.decay     = 16'(pick_value(40000, 65535));
            t.rise      = 16'(($urandom_range(3) == 0) ? pick_value(0, 65535)
                                                       : pick_value(256, 1536));
            t.floor_lvl = 16'(($urandom_range(4) == 0) ? pick_value(32768, 65535)
                                                       : pick_value(0, 3000));
            t.spacing   = 24'(($urandom_range(5) == 0) ? pick_value(0, 24'hFFFFFF)
                                                       : pick_value(0, 24));
            load_tuning(t, 8'($urandom));
            steady = (p == STEADY_PHASE);
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(pick_sample(), (i == 0) || ($urandom_range(49) == 0));
            steady = 1'b0;
        end

        wait_drained();
        $display("%0d words over %0d register settings, %0d onsets and %0d quiet samples",
                 sent, settings, sb.onsets, sb.quiet);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
